[design/fkr_pkg.sv]
// Shared types, constants and codes for the keyed-removal queue.
package fkr_pkg;

	localparam int DEPTH     = 16;
	localparam int KEY_BITS  = 16;
	localparam int DATA_BITS = 32;
	localparam int IDX_W     = $clog2(DEPTH);
	localparam int CNT_W     = $clog2(DEPTH + 1);

	// Action codes
	localparam logic [2:0] ACT_PUSH   = 3'd0;
	localparam logic [2:0] ACT_POP    = 3'd1;
	localparam logic [2:0] ACT_FIND   = 3'd2;
	localparam logic [2:0] ACT_REMOVE = 3'd3;
	localparam logic [2:0] ACT_CLEAR  = 3'd4;

	// Status codes
	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_EMPTY     = 2'd1;
	localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
	localparam logic [1:0] STAT_FULL      = 2'd3;

	typedef struct packed {
		logic [2:0]           action;
		logic [KEY_BITS-1:0]  student_number;
		logic [DATA_BITS-1:0] grade_data;
	} req_t;

	typedef struct packed {
		logic [1:0]           status;
		logic                 found;
		logic [CNT_W-1:0]     count;
		logic [KEY_BITS-1:0]  front_key;
		logic [DATA_BITS-1:0] front_data;
		logic [KEY_BITS-1:0]  back_key;
		logic [DATA_BITS-1:0] back_data;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_EXEC
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic load;   // capture the incoming request
		logic cmp;    // register the key compare against all entries
		logic exec;   // apply the action and load the result register
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic out_free; // result register can take a new result this cycle
	} dp_stat_t;

endpackage

[design/fifo_with_keyed_removal.sv]
// Top level of the ordered record queue with search and removal by key.
//
//  channel | direction | handshake              | payload
//  req     | in        | req_valid / req_ready  | fkr_pkg::req_t (action, key, data)
//  rsp     | out       | rsp_valid / rsp_ready  | fkr_pkg::rsp_t (status, found, count, ends)
//
// A request is handled in steps: the key compare against all entries is registered,
// then the store is updated and the result register loaded.
// A back-to-back request is taken as the previous one executes, while the result side drains.
// The result register holds one result; a stalled result stops the execute step.
// Reset clears the record count; the store contents need no reset.
module fifo_with_keyed_removal (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  fkr_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output fkr_pkg::rsp_t  rsp
);
	import fkr_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	fkr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	fkr_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

[design/fkr_ctrl.sv]
// Sequencer for the keyed-removal queue: capture, compare, execute.
module fkr_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  fkr_pkg::dp_stat_t  stat,
	output fkr_pkg::dp_cmd_t   cmd
);
	import fkr_pkg::*;

	state_t state_q;
	state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		cmd       = '0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CMP;
				end
			end
			ST_CMP: begin
				cmd.cmp = 1'b1;
				state_d = ST_EXEC;
			end
			ST_EXEC: begin
				// hold until the result register is free, then take the next request
				if (stat.out_free) begin
					cmd.exec  = 1'b1;
					req_ready = 1'b1;
					if (req_valid) begin
						cmd.load = 1'b1;
						state_d  = ST_CMP;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

[design/fkr_dp.sv]
// Datapath of the keyed-removal queue: record store, key compare, result register.
module fkr_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  fkr_pkg::dp_cmd_t  cmd,
	output fkr_pkg::dp_stat_t stat,
	input  fkr_pkg::req_t     req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output fkr_pkg::rsp_t     rsp
);
	import fkr_pkg::*;

	req_t                 req_q;
	logic [KEY_BITS-1:0]  key_q  [DEPTH];
	logic [DATA_BITS-1:0] data_q [DEPTH];
	logic [CNT_W-1:0]     cnt_q;
	logic [DEPTH-1:0]     match_q;
	rsp_t                 out_q;
	logic                 out_valid_q;

	logic [KEY_BITS-1:0]  key_d  [DEPTH];
	logic [DATA_BITS-1:0] data_d [DEPTH];
	logic [CNT_W-1:0]     cnt_d;
	logic [DEPTH-1:0]     first_oh;
	logic [DEPTH-1:0]     shift_mask;
	logic                 do_shift;
	logic                 do_push;
	logic [CNT_W-1:0]     back_idx;
	logic [1:0]           status_d;
	logic                 found_d;
	rsp_t                 rsp_d;

	assign stat.out_free = !out_valid_q || rsp_ready;

	// Capture the request
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
	end

	// Compare the key against every held entry
	always_ff @(posedge clk) begin
		if (cmd.cmp) begin
			for (int i = 0; i < DEPTH; i++) begin
				match_q[i] <= (CNT_W'(i) < cnt_q) && (key_q[i] == req_q.student_number);
			end
		end
	end

	// Isolate the match nearest the front; entries from there on move forward
	assign first_oh   = match_q & (~match_q + DEPTH'(1));
	assign shift_mask = ~(first_oh - DEPTH'(1));

	// Decide the action
	always_comb begin
		status_d = STAT_OK;
		found_d  = 1'b0;
		cnt_d    = cnt_q;
		do_shift = 1'b0;
		do_push  = 1'b0;
		case (req_q.action)
			ACT_PUSH: begin
				if (cnt_q == CNT_W'(DEPTH)) begin
					status_d = STAT_FULL;
				end else begin
					do_push = 1'b1;
					cnt_d   = cnt_q + CNT_W'(1);
				end
			end
			ACT_POP: begin
				if (cnt_q == '0) begin
					status_d = STAT_EMPTY;
				end else begin
					do_shift = 1'b1;
					cnt_d    = cnt_q - CNT_W'(1);
				end
			end
			ACT_FIND, ACT_REMOVE: begin
				if (cnt_q == '0) begin
					status_d = STAT_EMPTY;
				end else if (match_q == '0) begin
					status_d = STAT_NOT_FOUND;
				end else begin
					found_d = 1'b1;
					if (req_q.action == ACT_REMOVE) begin
						do_shift = 1'b1;
						cnt_d    = cnt_q - CNT_W'(1);
					end
				end
			end
			ACT_CLEAR: begin
				cnt_d = '0;
			end
			default: begin
				status_d = STAT_OK;
			end
		endcase
	end

	// Next store contents: push at the back or close the gap
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			key_d[i]  = key_q[i];
			data_d[i] = data_q[i];
			if (do_push && (cnt_q[IDX_W-1:0] == IDX_W'(i))) begin
				key_d[i]  = req_q.student_number;
				data_d[i] = req_q.grade_data;
			end
			if (do_shift && i < DEPTH - 1) begin
				// pop moves every entry; removal moves those at and behind the match
				if (req_q.action == ACT_POP || shift_mask[i]) begin
					key_d[i]  = key_q[(i + 1) % DEPTH];
					data_d[i] = data_q[(i + 1) % DEPTH];
				end
			end
		end
	end

	// Build the result from the updated queue
	assign back_idx = cnt_d - CNT_W'(1);

	always_comb begin
		rsp_d        = '0;
		rsp_d.status = status_d;
		rsp_d.found  = found_d;
		rsp_d.count  = cnt_d;
		if (cnt_d != '0) begin
			rsp_d.front_key  = key_d[0];
			rsp_d.front_data = data_d[0];
			rsp_d.back_key   = key_d[back_idx[IDX_W-1:0]];
			rsp_d.back_data  = data_d[back_idx[IDX_W-1:0]];
		end
	end

	// Advance the store
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			for (int i = 0; i < DEPTH; i++) begin
				key_q[i]  <= key_d[i];
				data_q[i] <= data_d[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.exec) begin
			cnt_q <= cnt_d;
		end
	end

	// Result register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.exec) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			out_q <= rsp_d;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

`ifndef SYNTH
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("record count beyond store depth");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |-> (!out_valid_q || rsp_ready))
		else $error("result written over an untaken result");

	a_exec_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> out_valid_q)
		else $error("executed request left no result");

	a_cnt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.exec |=> cnt_q == $past(cnt_q))
		else $error("record count moved without an executed request");
`endif

endmodule

[sim/fkr_outcome_checker.sv]
// Checker for the keyed-removal queue: tracks the queue contents and compares every result.
`timescale 1ns / 100ps

module fkr_outcome_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  logic           req_ready,
	input  fkr_pkg::req_t  req,
	input  logic           rsp_valid,
	input  logic           rsp_ready,
	input  fkr_pkg::rsp_t  rsp,
	output int             fail_count,
	output int             outstanding,
	output int             compared,
	output int             full_hits,
	output int             key_hits
);
	import fkr_pkg::*;

	// Shadow copy of the record store; entry 0 is the front
	logic [KEY_BITS-1:0]  shadow_keys [DEPTH];
	logic [DATA_BITS-1:0] shadow_data [DEPTH];
	int                   shadow_held;
	rsp_t                 outcome_q [$];

	initial begin
		fail_count  = 0;
		outstanding = 0;
		compared    = 0;
		full_hits   = 0;
		key_hits    = 0;
		shadow_held = 0;
	end

	// Drop entry pos and close the gap, keeping the order of the rest
	function automatic void close_gap(int pos);
		for (int i = pos; i < shadow_held - 1; i++) begin
			shadow_keys[i] = shadow_keys[i + 1];
			shadow_data[i] = shadow_data[i + 1];
		end
		shadow_held--;
	endfunction

	// Apply one request to the shadow store and work out the result it gives
	function automatic rsp_t queue_outcome(req_t r);
		rsp_t o;
		int   pos;
		o        = '0;
		o.status = STAT_OK;
		case (r.action)
			ACT_PUSH: begin
				if (shadow_held >= DEPTH) begin
					o.status = STAT_FULL;
					full_hits++;
				end else begin
					shadow_keys[shadow_held] = r.student_number;
					shadow_data[shadow_held] = r.grade_data;
					shadow_held++;
				end
			end
			ACT_POP: begin
				if (shadow_held == 0)
					o.status = STAT_EMPTY;
				else
					close_gap(0);
			end
			ACT_FIND, ACT_REMOVE: begin
				if (shadow_held == 0) begin
					o.status = STAT_EMPTY;
				end else begin
					// first match nearest the front wins
					pos = shadow_held;
					for (int i = shadow_held - 1; i >= 0; i--)
						if (shadow_keys[i] == r.student_number)
							pos = i;
					if (pos == shadow_held) begin
						o.status = STAT_NOT_FOUND;
					end else begin
						o.found = 1'b1;
						key_hits++;
						if (r.action == ACT_REMOVE)
							close_gap(pos);
					end
				end
			end
			ACT_CLEAR: shadow_held = 0;
			default: ;
		endcase
		o.count = CNT_W'(shadow_held);
		if (shadow_held != 0) begin
			o.front_key  = shadow_keys[0];
			o.front_data = shadow_data[0];
			o.back_key   = shadow_keys[shadow_held - 1];
			o.back_data  = shadow_data[shadow_held - 1];
		end
		return o;
	endfunction

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endfunction

	// Retire results first: a request taken on the same edge cannot have its result yet
	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			shadow_held = 0;
			outcome_q.delete();
			outstanding <= 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (outcome_q.size() == 0) begin
					$error("result with no request outstanding: %p", rsp);
					fail_count++;
				end else begin
					want = outcome_q[0];
					outcome_q.delete(0);
					check_field("status",     want.status,     rsp.status);
					check_field("found",      want.found,      rsp.found);
					check_field("count",      want.count,      rsp.count);
					check_field("front_key",  want.front_key,  rsp.front_key);
					check_field("front_data", want.front_data, rsp.front_data);
					check_field("back_key",   want.back_key,   rsp.back_key);
					check_field("back_data",  want.back_data,  rsp.back_data);
					compared++;
				end
			end
			if (req_valid && req_ready)
				outcome_q.insert(outcome_q.size(), queue_outcome(req));
			outstanding <= outcome_q.size();
		end
	end

endmodule

[sim/tb_top.sv]
// Testbench top for the keyed-removal queue: clock, reset, request stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;
	import fkr_pkg::*;

	localparam int RANDOM_REQUESTS = 1450;

	typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED, MIX_NOISE} mix_t;
	typedef enum int {RX_OPEN, RX_HOLD, RX_CHOPPY} rx_t;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	int fail_count;
	int outstanding;
	int compared;
	int full_hits;
	int key_hits;

	int   sent_by_action [8];
	int   burst_left = 0;
	bit   valid_held = 1'b0;
	rx_t  rx_mode    = RX_OPEN;
	int   rx_left    = 0;

	always #5 clk = ~clk;

	fifo_with_keyed_removal u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	fkr_outcome_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.rsp         (rsp),
		.fail_count  (fail_count),
		.outstanding (outstanding),
		.compared    (compared),
		.full_hits   (full_hits),
		.key_hits    (key_hits)
	);

	// Present one request, hold it until taken, then maybe pause before the next burst
	task automatic send_request(input logic [2:0] action, input logic [KEY_BITS-1:0] key,
			input logic [DATA_BITS-1:0] data);
		int gap;
		req        <= '{action: action, student_number: key, grade_data: data};
		req_valid  <= 1'b1;
		valid_held = 1'b1;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		sent_by_action[action]++;
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			if ($urandom_range(0, 7) == 0) begin
				burst_left = $urandom_range(40, 120);
				gap        = 0;
			end else begin
				burst_left = $urandom_range(1, 10);
				gap        = $urandom_range(1, 6);
			end
			if (gap > 0) begin
				req_valid  <= 1'b0;
				valid_held = 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Stall the result side in stretches: open, held off, or choppy
	always @(posedge clk) begin
		if (rx_left == 0) begin
			case ($urandom_range(0, 3))
				0: begin rx_mode = RX_OPEN;   rx_left = $urandom_range(50, 150); end
				1: begin rx_mode = RX_HOLD;   rx_left = $urandom_range(1, 12);   end
				2: begin rx_mode = RX_CHOPPY; rx_left = $urandom_range(10, 30);  end
				default: begin rx_mode = RX_OPEN; rx_left = $urandom_range(5, 40); end
			endcase
		end else begin
			rx_left--;
		end
		case (rx_mode)
			RX_OPEN:   rsp_ready <= 1'b1;
			RX_HOLD:   rsp_ready <= 1'b0;
			default:   rsp_ready <= 1'($urandom_range(0, 1));
		endcase
	end

	// Hard stop in case the block hangs
	initial begin
		#5_000_000;
		$display("tb_top: done, errors");
		$finish;
	end

	initial begin
		logic [KEY_BITS-1:0] key_pool [8];
		mix_t                mix;
		int                  epoch_len;
		int                  taken;
		int                  roll;
		logic [2:0]          action;
		logic [KEY_BITS-1:0] key;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty queue, extremes, duplicates, misses, unused codes, clear
		send_request(ACT_POP,    16'h0000, 32'h0000_0000);
		send_request(ACT_FIND,   16'hFFFF, 32'hFFFF_FFFF);
		send_request(ACT_REMOVE, 16'h0000, 32'hA5A5_A5A5);
		send_request(ACT_PUSH,   16'h0000, 32'h0000_0000);
		send_request(ACT_PUSH,   16'hFFFF, 32'hFFFF_FFFF);
		send_request(ACT_PUSH,   16'h0000, 32'h5A5A_5A5A);
		send_request(ACT_FIND,   16'hFFFF, 32'h1234_5678);
		send_request(ACT_FIND,   16'h1234, 32'h0000_0000);
		send_request(ACT_REMOVE, 16'h1234, 32'h0000_0000);
		send_request(ACT_REMOVE, 16'h0000, 32'hFFFF_FFFF);
		send_request(3'd5, 16'hFFFF, 32'hFFFF_FFFF);
		send_request(3'd6, 16'h0000, 32'h0000_0000);
		send_request(3'd7, 16'h8001, 32'h8000_0001);
		send_request(ACT_POP,    16'hFFFF, 32'h0000_0000);
		send_request(ACT_PUSH,   16'h8001, 32'h8000_0001);
		send_request(ACT_CLEAR,  16'hFFFF, 32'hFFFF_FFFF);
		send_request(ACT_POP,    16'h0000, 32'h0000_0000);
		send_request(ACT_CLEAR,  16'h0000, 32'h0000_0000);

		// Random: epochs that fill, drain or churn the queue over a small key pool
		taken = 0;
		while (taken < RANDOM_REQUESTS) begin
			mix       = mix_t'($urandom_range(0, 3));
			epoch_len = $urandom_range(10, 60);
			foreach (key_pool[i]) begin
				case ($urandom_range(0, 5))
					0:       key_pool[i] = '0;
					1:       key_pool[i] = '1;
					default: key_pool[i] = KEY_BITS'($urandom);
				endcase
			end
			for (int n = 0; n < epoch_len && taken < RANDOM_REQUESTS; n++) begin
				roll = $urandom_range(0, 99);
				case (mix)
					MIX_FILL:
						action = roll < 70 ? ACT_PUSH : roll < 80 ? ACT_FIND :
							roll < 90 ? ACT_REMOVE : roll < 97 ? ACT_POP :
							roll < 98 ? ACT_CLEAR : 3'($urandom_range(5, 7));
					MIX_DRAIN:
						action = roll < 25 ? ACT_PUSH : roll < 55 ? ACT_POP :
							roll < 80 ? ACT_REMOVE : roll < 95 ? ACT_FIND :
							roll < 97 ? ACT_CLEAR : 3'($urandom_range(5, 7));
					MIX_BALANCED:
						action = roll < 40 ? ACT_PUSH : roll < 55 ? ACT_POP :
							roll < 75 ? ACT_FIND : roll < 95 ? ACT_REMOVE :
							roll < 97 ? ACT_CLEAR : 3'($urandom_range(5, 7));
					default:
						action = 3'($urandom_range(0, 7));
				endcase
				if (mix != MIX_NOISE && $urandom_range(0, 99) < 85)
					key = key_pool[$urandom_range(0, 7)];
				else
					key = KEY_BITS'($urandom);
				send_request(action, key, DATA_BITS'($urandom));
				taken++;
			end
		end

		// Drain: release the request line, wait for every result, then settle
		if (valid_held)
			req_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("tb_top: sent push %0d, pop %0d, find %0d, remove %0d, clear %0d, unused %0d",
			sent_by_action[ACT_PUSH], sent_by_action[ACT_POP], sent_by_action[ACT_FIND],
			sent_by_action[ACT_REMOVE], sent_by_action[ACT_CLEAR],
			sent_by_action[5] + sent_by_action[6] + sent_by_action[7]);
		$display("tb_top: %0d results compared, %0d pushes refused when full, %0d key matches",
			compared, full_hits, key_hits);
		if (fail_count == 0 && outstanding == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
